FILE: rtl/core/fdds_pkg.sv
// ----------------------------------------------------------------------------
// fdds_pkg: shared types and constants of the display serializer
// Payload structs, operation codes, phase sequencer states, segment table.
// ----------------------------------------------------------------------------
package fdds_pkg;

	localparam int unsigned VALUE_W = 14;
	localparam int unsigned WR_IDX_W = 3;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_SHOW   = 2'd1,
		OP_BRIGHT = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [VALUE_W-1:0] shown_value;
		logic [2:0]         dot_position;
		logic [3:0]         brightness_level;
	} in_t;

	typedef struct packed {
		logic clock_pin;
		logic data_pin;
		logic busy_res;
		logic frame_end;
		logic command_rejected;
	} out_t;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_START = 5'b00010,
		PH_BIT   = 5'b00100,
		PH_ACK   = 5'b01000,
		PH_STOP  = 5'b10000
	} ph_state_t;

	// Command to the phase sequencer for the item being processed
	typedef struct packed {
		logic load;
		logic tick;
		logic is_number;
	} seq_cmd_t;

	// Line levels and status after the item being processed
	typedef struct packed {
		logic clock_level;
		logic data_level;
		logic sending;
		logic frame_end;
	} seq_stat_t;

	// Segment byte write from the digit unit
	typedef struct packed {
		logic                we;
		logic [WR_IDX_W-1:0] idx;
		logic [7:0]          data;
	} dig_wr_t;

	localparam logic [7:0]  ADDR_CMD   = 8'hC0;
	localparam logic [7:0]  BRIGHT_CMD = 8'h88;
	localparam logic [7:0]  POINT_BIT  = 8'h80;
	localparam logic [3:0]  MAX_BRIGHT = 4'd7;
	localparam logic [2:0]  LAST_BIT   = 3'd7;
	// floor(x * 6554 / 2^16) == floor(x / 10) for every 14-bit x
	localparam logic [12:0] RECIP_TEN  = 13'd6554;

	function automatic logic [7:0] seg_of(input logic [3:0] digit);
		logic [7:0] seg;
		case (digit)
			4'd0: seg = 8'h3f;
			4'd1: seg = 8'h06;
			4'd2: seg = 8'h5b;
			4'd3: seg = 8'h4f;
			4'd4: seg = 8'h66;
			4'd5: seg = 8'h6d;
			4'd6: seg = 8'h7d;
			4'd7: seg = 8'h07;
			4'd8: seg = 8'h7f;
			4'd9: seg = 8'h6f;
			default: seg = 8'h00;
		endcase
		return seg;
	endfunction

endpackage

FILE: rtl/core/fdds_digit_conv.sv
// ----------------------------------------------------------------------------
// fdds_digit_conv: iterative decimal digit unit
// Peels one decimal digit per cycle off the shown value, rightmost first,
// and writes its segment byte (with the point where the dot position selects it) into the frame store.
// ----------------------------------------------------------------------------
module fdds_digit_conv
	import fdds_pkg::*;
#(
	parameter int unsigned DIGIT_COUNT = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VALUE_W-1:0] value,
	input  logic [2:0]         dot,
	output dig_wr_t            wr
);

	localparam int unsigned IDX_W = $clog2(DIGIT_COUNT + 1);

	logic [IDX_W-1:0]   cnt_q;
	logic [VALUE_W-1:0] rem_q;
	logic [2:0]         dot_q;

	logic [VALUE_W+12:0] prod;
	logic [VALUE_W-1:0]  quot;
	logic [VALUE_W-1:0]  quot_x10;
	logic [VALUE_W-1:0]  diff;
	logic [7:0]          seg;

	always_comb begin
		prod     = (VALUE_W+13)'(rem_q) * (VALUE_W+13)'(RECIP_TEN);
		quot     = VALUE_W'(prod[VALUE_W+12:16]);
		quot_x10 = (quot << 3) + (quot << 1);
		diff     = rem_q - quot_x10;
		seg      = seg_of(diff[3:0]);
		if (dot_q == 3'(cnt_q)) begin
			seg = seg | POINT_BIT;
		end
	end

	assign wr.we   = (cnt_q != '0);
	assign wr.idx  = WR_IDX_W'(cnt_q);
	assign wr.data = seg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= IDX_W'(DIGIT_COUNT);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			dot_q <= dot;
		end else if (cnt_q != '0) begin
			rem_q <= quot;
		end
	end

endmodule

FILE: rtl/core/fdds_phase_seq.sv
// ----------------------------------------------------------------------------
// fdds_phase_seq: two-wire waveform phase sequencer
// Walks start, bit, acknowledge and stop phases one tick at a time and
// holds the current clock and data line levels.
// ----------------------------------------------------------------------------
module fdds_phase_seq
	import fdds_pkg::*;
#(
	parameter int unsigned DIGIT_COUNT = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  seq_cmd_t                             cmd,
	input  logic [7:0]                           cur_byte,
	output logic [$clog2(DIGIT_COUNT + 1)-1:0]   byte_idx,
	output logic                                 sending,
	output seq_stat_t                            stat
);

	localparam int unsigned IDX_W = $clog2(DIGIT_COUNT + 1);

	ph_state_t        state_q, state_d;
	logic [1:0]       cnt_q, cnt_d;
	logic [2:0]       bit_q, bit_d;
	logic [IDX_W-1:0] byte_q, byte_d;
	logic             is_num_q, is_num_d;
	logic             clk_q, clk_d;
	logic             dat_q, dat_d;
	logic             end_d;
	logic             last_byte;

	assign byte_idx  = byte_q;
	assign sending   = (state_q != PH_IDLE);
	assign last_byte = is_num_q ? (byte_q == IDX_W'(DIGIT_COUNT)) : (byte_q == '0);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		bit_d    = bit_q;
		byte_d   = byte_q;
		is_num_d = is_num_q;
		clk_d    = clk_q;
		dat_d    = dat_q;
		end_d    = 1'b0;
		if (cmd.load) begin
			state_d  = PH_START;
			cnt_d    = 2'd0;
			is_num_d = cmd.is_number;
		end else if (cmd.tick) begin
			case (state_q)
				PH_IDLE: begin
				end
				PH_START: begin
					clk_d = (cnt_q != 2'd2);
					dat_d = (cnt_q == 2'd0);
					if (cnt_q == 2'd2) begin
						state_d = PH_BIT;
						cnt_d   = 2'd0;
						bit_d   = 3'd0;
						byte_d  = '0;
					end else begin
						cnt_d = cnt_q + 2'd1;
					end
				end
				PH_BIT: begin
					clk_d = (cnt_q == 2'd2);
					dat_d = (cnt_q == 2'd0) ? dat_q : cur_byte[bit_q];
					if (cnt_q == 2'd2) begin
						cnt_d = 2'd0;
						if (bit_q == LAST_BIT) begin
							state_d = PH_ACK;
						end else begin
							bit_d = bit_q + 3'd1;
						end
					end else begin
						cnt_d = cnt_q + 2'd1;
					end
				end
				PH_ACK: begin
					clk_d = (cnt_q == 2'd1);
					if (cnt_q == 2'd1) begin
						cnt_d = 2'd0;
						if (last_byte) begin
							state_d = PH_STOP;
						end else begin
							state_d = PH_BIT;
							bit_d   = 3'd0;
							byte_d  = byte_q + IDX_W'(1);
						end
					end else begin
						cnt_d = cnt_q + 2'd1;
					end
				end
				PH_STOP: begin
					clk_d = (cnt_q != 2'd0);
					dat_d = (cnt_q == 2'd2);
					if (cnt_q == 2'd2) begin
						state_d = PH_IDLE;
						cnt_d   = 2'd0;
						end_d   = 1'b1;
					end else begin
						cnt_d = cnt_q + 2'd1;
					end
				end
				default: begin
					state_d = PH_IDLE;
				end
			endcase
		end
	end

	assign stat.clock_level = clk_d;
	assign stat.data_level  = dat_d;
	assign stat.sending     = (state_d != PH_IDLE);
	assign stat.frame_end   = end_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= PH_IDLE;
			cnt_q    <= 2'd0;
			bit_q    <= 3'd0;
			byte_q   <= '0;
			is_num_q <= 1'b0;
			clk_q    <= 1'b0;
			dat_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			bit_q    <= bit_d;
			byte_q   <= byte_d;
			is_num_q <= is_num_d;
			clk_q    <= clk_d;
			dat_q    <= dat_d;
		end
	end

endmodule

FILE: rtl/core/four_digit_display_serializer_top.sv
// ----------------------------------------------------------------------------
// four_digit_display_serializer_top: seven-segment display link serializer
// Turns show, brightness and tick commands into clock/data line phases.
// ----------------------------------------------------------------------------
// One item per clock cycle while out_ready keeps up: an input register feeds
// the phase sequencer and command decode, and a result register presents the
// line levels. The result register frees the input side, so a new item is
// taken while a result still waits on out_ready.
// A show command hands the value to a digit unit that extracts one decimal
// digit per cycle; this completes long before the sequencer reaches the first
// digit byte, which takes at least 29 ticks after the command. Each tick item
// advances the waveform by one phase step; a command that arrives while a
// frame is still in flight is dropped and flagged.
module four_digit_display_serializer_top
	import fdds_pkg::*;
#(
	parameter int unsigned DIGIT_COUNT = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int unsigned IDX_W = $clog2(DIGIT_COUNT + 1);
	localparam int unsigned SLOTS = DIGIT_COUNT + 1;

	// input stage
	logic in_valid_s1;
	in_t  in_data_s1;

	// result register
	logic out_valid_q;
	out_t out_data_q;

	logic proceed;
	logic is_cmd;
	logic accept_cmd;
	logic reject;

	seq_cmd_t         seq_cmd;
	seq_stat_t        seq_stat;
	logic             sending;
	logic [IDX_W-1:0] byte_idx;
	logic [7:0]       cur_byte;
	dig_wr_t          dig_wr;

	logic [7:0] frame_bytes_q [SLOTS];
	logic [7:0] first_byte;
	logic [3:0] bright_clamped;

	// advance the input stage whenever the result register is free or drains
	assign proceed   = in_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !in_valid_s1 || proceed;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_data_s1 <= in_data;
		end
	end

	// command decode: a show or brightness command loads a frame only when idle
	assign is_cmd     = (in_data_s1.operation == OP_SHOW) ||
	                    (in_data_s1.operation == OP_BRIGHT);
	assign accept_cmd = proceed && is_cmd && !sending;
	assign reject     = is_cmd && sending;

	assign seq_cmd.load      = accept_cmd;
	assign seq_cmd.tick      = proceed && (in_data_s1.operation == OP_TICK);
	assign seq_cmd.is_number = (in_data_s1.operation == OP_SHOW);

	fdds_phase_seq #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_phase_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (seq_cmd),
		.cur_byte (cur_byte),
		.byte_idx (byte_idx),
		.sending  (sending),
		.stat     (seq_stat)
	);

	fdds_digit_conv #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_digit_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept_cmd && seq_cmd.is_number),
		.value  (in_data_s1.shown_value),
		.dot    (in_data_s1.dot_position),
		.wr     (dig_wr)
	);

	// frame byte store: slot zero from the command, digit slots from the digit unit
	always_comb begin
		bright_clamped = (in_data_s1.brightness_level > MAX_BRIGHT) ?
		                 MAX_BRIGHT : in_data_s1.brightness_level;
		first_byte     = seq_cmd.is_number ? ADDR_CMD :
		                 (BRIGHT_CMD + 8'(bright_clamped));
	end

	always_ff @(posedge clk) begin
		if (accept_cmd) begin
			frame_bytes_q[0] <= first_byte;
		end
		if (dig_wr.we) begin
			frame_bytes_q[dig_wr.idx[IDX_W-1:0]] <= dig_wr.data;
		end
	end

	assign cur_byte = frame_bytes_q[byte_idx];

	// result register: hold until the downstream side takes the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proceed) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proceed) begin
			out_data_q.clock_pin        <= seq_stat.clock_level;
			out_data_q.data_pin         <= seq_stat.data_level;
			out_data_q.busy_res         <= seq_stat.sending;
			out_data_q.frame_end        <= seq_stat.frame_end;
			out_data_q.command_rejected <= reject;
		end
	end

	// the last stop phase always leaves the link idle
	a_end_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.frame_end |-> !out_data_q.busy_res)
		else $error("frame end reported while still busy");

	// a command is only dropped while a frame is in flight
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.command_rejected |-> out_data_q.busy_res)
		else $error("command rejected while idle");

	// an empty result register never stalls the input side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result register");

	// a new frame never starts while the digit unit still writes the previous one
	a_digits_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept_cmd |-> !dig_wr.we)
		else $error("frame loaded during digit extraction");

endmodule
